### rtl/ffaba_pkg.sv
package ffaba_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_TOO_LARGE  = 3'd1;
  localparam status_t ST_NO_FIT     = 3'd2;
  localparam status_t ST_TABLE_FULL = 3'd3;
  localparam status_t ST_NOT_FOUND  = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [31:0] CHUNK_RESET = 32'd1048576;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    scan;
    logic    align;
    logic    wr_head;
    logic    wr_tail;
    logic    wr_free;
    logic    load_out;
    status_t code;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic too_large;
    logic hit;
    logic hit_exact;
    logic exhausted;
    logic full;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/ffaba_dp.sv
module ffaba_dp #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffaba_pkg::ctl_cmd_t cmd,
  output ffaba_pkg::dp_stat_t st,
  input  logic                in_func,
  input  logic [31:0]         in_req_size,
  input  logic [4:0]          in_alignment_log2,
  input  logic [31:0]         in_block_offset,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffaba_pkg::status_t  out_status,
  output logic [31:0]         out_offset,
  output logic [31:0]         out_granted_size
);
  import ffaba_pkg::*;

  localparam int AB   = ADDR_BITS;
  localparam int CW   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);

  // block table
  logic [AB-1:0] mem_off [MAX_BLOCKS];
  logic [AB-1:0] mem_len [MAX_BLOCKS];
  logic          mem_free [MAX_BLOCKS];

  logic          we;
  logic [IW-1:0] waddr;
  logic [AB-1:0] wd_off;
  logic [AB-1:0] wd_len;
  logic          wd_free;

  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] scan_cnt_r;
  logic [31:0]     chunk_r;

  // latched request
  logic          func_r;
  logic [31:0]   size_r;
  logic [4:0]    align_r;
  logic [AB-1:0] tgt_r;

  // scan pipeline
  logic          issue;
  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IW-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic [AB-1:0] rd_off_r, s2_off_r, s3_off_r;
  logic [AB-1:0] rd_len_r, s2_len_r, s3_len_r;
  logic          rd_free_r, s2_free_r, s3_free_r;
  logic [CW-1:0] s2_pad_r, s3_pad_r;
  logic [CW-1:0] s3_avail_r;
  logic          s3_borrow_r;

  logic [CW-1:0] amask;
  logic [CW-1:0] pad_nxt;
  logic [CW:0]   diff;
  logic [CW-1:0] size_cw;
  logic          hit;

  // selected block
  logic [IW-1:0] sel_idx_r;
  logic [AB-1:0] sel_off_r;
  logic [AB-1:0] sel_len_r;
  logic [CW-1:0] sel_pad_r;
  logic [CW-1:0] sel_avail_r;
  logic          sel_exact_r;

  logic [AB-1:0] aoff_r;
  logic [CW-1:0] grant_r;
  logic [CW-1:0] rem_r;
  logic [AB-1:0] tail_r;
  logic [CW-1:0] aoff_sum;
  logic [CW-1:0] tail_sum;
  logic [CW-1:0] tgt_cw;
  logic [CW-1:0] cfg_cw;
  logic [CW-1:0] rst_cw;
  logic [CW-1:0] aoff_cw;
  logic          ok_alloc;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [31:0]   out_offset_r;
  logic [31:0]   out_granted_r;

  assign size_cw = CW'(size_r);
  assign tgt_cw  = CW'(in_block_offset);
  assign cfg_cw  = CW'(cfg_wr_data);
  assign rst_cw  = CW'(CHUNK_RESET);
  assign issue   = cmd.scan && (scan_cnt_r < count_r);

  assign amask   = (CW'(1) << align_r) - CW'(1);
  assign pad_nxt = (CW'(0) - CW'(rd_off_r)) & amask;
  assign diff    = {1'b0, CW'(s2_len_r)} - {1'b0, s2_pad_r};

  assign aoff_sum = CW'(sel_off_r) + sel_pad_r;
  assign tail_sum = CW'(aoff_r) + size_cw;
  assign aoff_cw  = CW'(aoff_r);

  always_comb begin
    if (func_r == FUNC_ALLOC) begin
      hit = s3_vld_r && s3_free_r && !s3_borrow_r && (s3_avail_r >= size_cw);
    end else begin
      hit = s3_vld_r && !s3_free_r && (s3_off_r == tgt_r);
    end
  end

  always_comb begin
    st.is_alloc  = (func_r == FUNC_ALLOC);
    st.too_large = (size_r > chunk_r);
    st.hit       = hit;
    st.hit_exact = (s3_avail_r == size_cw);
    st.exhausted = (scan_cnt_r >= count_r) && !s1_vld_r && !s2_vld_r && !s3_vld_r;
    st.full      = (count_r >= CNTW'(MAX_BLOCKS));
    st.out_free  = !out_valid_r || !out_stall;
  end

  // table write port: init on reset or chunk write, else one update per cycle
  always_comb begin
    we      = 1'b0;
    waddr   = sel_idx_r;
    wd_off  = aoff_r;
    wd_len  = grant_r[AB-1:0];
    wd_free = 1'b0;
    priority if (!rst_n) begin
      we      = 1'b1;
      waddr   = '0;
      wd_off  = '0;
      wd_len  = rst_cw[AB-1:0];
      wd_free = 1'b1;
    end else if (cfg_wr_en) begin
      we      = 1'b1;
      waddr   = '0;
      wd_off  = '0;
      wd_len  = cfg_cw[AB-1:0];
      wd_free = 1'b1;
    end else if (cmd.wr_head) begin
      we = 1'b1;
    end else if (cmd.wr_tail) begin
      we      = 1'b1;
      waddr   = count_r[IW-1:0];
      wd_off  = tail_r;
      wd_len  = rem_r[AB-1:0];
      wd_free = 1'b1;
    end else if (cmd.wr_free) begin
      we      = 1'b1;
      wd_off  = sel_off_r;
      wd_len  = sel_len_r;
      wd_free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_off[waddr]  <= wd_off;
      mem_len[waddr]  <= wd_len;
      mem_free[waddr] <= wd_free;
    end
    if (issue) begin
      rd_off_r  <= mem_off[scan_cnt_r[IW-1:0]];
      rd_len_r  <= mem_len[scan_cnt_r[IW-1:0]];
      rd_free_r <= mem_free[scan_cnt_r[IW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNTW'(1);
      chunk_r     <= CHUNK_RESET;
      scan_cnt_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunk_r <= cfg_wr_data;
        count_r <= CNTW'(1);
      end else if (cmd.wr_tail) begin
        count_r <= count_r + CNTW'(1);
      end
      if (cmd.accept) begin
        scan_cnt_r <= '0;
        s1_vld_r   <= 1'b0;
        s2_vld_r   <= 1'b0;
        s3_vld_r   <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) begin
          scan_cnt_r <= scan_cnt_r + CNTW'(1);
        end
        s1_vld_r <= issue;
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      size_r  <= in_req_size;
      align_r <= in_alignment_log2;
      tgt_r   <= tgt_cw[AB-1:0];
    end
    if (cmd.scan) begin
      if (issue) begin
        s1_idx_r <= scan_cnt_r[IW-1:0];
      end
      s2_idx_r    <= s1_idx_r;
      s2_off_r    <= rd_off_r;
      s2_len_r    <= rd_len_r;
      s2_free_r   <= rd_free_r;
      s2_pad_r    <= pad_nxt;
      s3_idx_r    <= s2_idx_r;
      s3_off_r    <= s2_off_r;
      s3_len_r    <= s2_len_r;
      s3_free_r   <= s2_free_r;
      s3_pad_r    <= s2_pad_r;
      s3_avail_r  <= diff[CW-1:0];
      s3_borrow_r <= diff[CW];
    end
    if (cmd.scan && hit) begin
      sel_idx_r   <= s3_idx_r;
      sel_off_r   <= s3_off_r;
      sel_len_r   <= s3_len_r;
      sel_pad_r   <= s3_pad_r;
      sel_avail_r <= s3_avail_r;
      sel_exact_r <= (s3_avail_r == size_cw);
    end
    if (cmd.align) begin
      aoff_r  <= aoff_sum[AB-1:0];
      grant_r <= sel_exact_r ? sel_avail_r : size_cw;
      rem_r   <= sel_avail_r - size_cw;
    end
    if (cmd.wr_head) begin
      tail_r <= tail_sum[AB-1:0];
    end
  end

  assign ok_alloc = (cmd.code == ST_OK) && (func_r == FUNC_ALLOC);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= cmd.code;
      out_offset_r  <= ok_alloc ? aoff_cw[31:0] : 32'd0;
      out_granted_r <= ok_alloc ? grant_r[31:0] : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_offset       = out_offset_r;
  assign out_granted_size = out_granted_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNTW'(1) && count_r <= CNTW'(MAX_BLOCKS))
    else $error("block count out of range");

  a_tail_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_tail && !cfg_wr_en) |=> count_r == $past(count_r) + CNTW'(1))
    else $error("appended block did not grow the table");
`endif

endmodule

### rtl/ffaba_ctrl.sv
module ffaba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output ffaba_pkg::ctl_cmd_t cmd,
  input  ffaba_pkg::dp_stat_t st
);
  import ffaba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ALIGN,
    S_WR_HEAD,
    S_WR_TAIL,
    S_WR_FREE,
    S_RESULT
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    split_r, split_nxt;
  logic    stall_r;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    split_nxt = split_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.is_alloc && st.too_large) begin
          code_nxt  = ST_TOO_LARGE;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st.hit) begin
          split_nxt = !st.hit_exact;
          priority if (!st.is_alloc) begin
            state_nxt = S_WR_FREE;
          end else if (!st.hit_exact && st.full) begin
            code_nxt  = ST_TABLE_FULL;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_ALIGN;
          end
        end else if (st.exhausted) begin
          code_nxt  = st.is_alloc ? ST_NO_FIT : ST_NOT_FOUND;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_ALIGN: begin
        state_nxt = S_WR_HEAD;
      end
      S_WR_HEAD: begin
        code_nxt  = ST_OK;
        state_nxt = split_r ? S_WR_TAIL : S_RESULT;
      end
      S_WR_TAIL: begin
        code_nxt  = ST_OK;
        state_nxt = S_RESULT;
      end
      S_WR_FREE: begin
        code_nxt  = ST_OK;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
      split_r <= 1'b0;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      split_r <= split_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  always_comb begin
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.scan     = (state_r == S_SCAN);
    cmd.align    = (state_r == S_ALIGN);
    cmd.wr_head  = (state_r == S_WR_HEAD);
    cmd.wr_tail  = (state_r == S_WR_TAIL);
    cmd.wr_free  = (state_r == S_WR_FREE);
    cmd.load_out = (state_r == S_RESULT) && st.out_free;
    cmd.code     = code_r;
  end

  assign in_stall = stall_r;

`ifndef SYNTH
  a_tail_only_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_TAIL) |-> split_r)
    else $error("tail append without a split");

  a_scan_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && st.hit) |=> state_r != S_SCAN)
    else $error("scan continued past a hit");

  a_ready_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.scan && !cmd.wr_head && !cmd.wr_tail && !cmd.wr_free)
    else $error("request taken while table update in flight");
`endif

endmodule

### rtl/first_fit_aligned_block_allocator.sv
// First-fit sub-allocator for one memory chunk. Requests (alloc or free) are
// taken one at a time; each gives exactly one result. A request walks the
// block table in order through the table memory, one entry per
// cycle, behind a three-stage read/align/compare pipeline. A request goes
// through accept, a size check, a scan of the live entries plus the pipeline
// drain, the align, head-write and tail-write steps for an aligned split (no
// split can happen at a full table), and the load of the result register, held
// for as long as that register still carries a result that waits on out_stall.
// A new request is taken while the previous result still waits on out_stall.
// Writing cfg_wr_data sets chunk_size and resets the table to one free block
// in the same cycle; write it only when no request is in flight.
module first_fit_aligned_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [31:0]        in_req_size,
  input  logic [4:0]         in_alignment_log2,
  input  logic [31:0]        in_block_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output ffaba_pkg::status_t out_status,
  output logic [31:0]        out_offset,
  output logic [31:0]        out_granted_size,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import ffaba_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  ffaba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  ffaba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_func           (in_func),
    .in_req_size       (in_req_size),
    .in_alignment_log2 (in_alignment_log2),
    .in_block_offset   (in_block_offset),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_offset        (out_offset),
    .out_granted_size  (out_granted_size)
  );

endmodule

### tb/sv/ffaba_checker.sv
module ffaba_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [31:0]        in_req_size,
  input  logic [4:0]         in_alignment_log2,
  input  logic [31:0]        in_block_offset,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ffaba_pkg::status_t out_status,
  input  logic [31:0]        out_offset,
  input  logic [31:0]        out_granted_size,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ffaba_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] granted;
  } grant_t;

  logic [31:0] chunk_bytes;
  logic [31:0] blk_off [TABLE_DEPTH];
  logic [31:0] blk_len [TABLE_DEPTH];
  logic        blk_free [TABLE_DEPTH];
  int          blk_count;
  grant_t      grants_due [$];
  int          errs;

  task automatic rebuild_table(input logic [31:0] bytes);
    chunk_bytes = bytes;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      blk_off[i] = '0;
      blk_len[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_len[0] = bytes;
    blk_free[0] = 1'b1;
    blk_count = 1;
  endtask

  function automatic grant_t predict_grant(input logic func, input logic [31:0] size,
                                           input logic [4:0] align_log2,
                                           input logic [31:0] target);
    grant_t      g;
    logic [63:0] align;
    logic [63:0] pad;
    logic [63:0] len;
    logic [63:0] avail;
    bit          found;
    g.status = ST_NO_FIT;
    g.offset = '0;
    g.granted = '0;
    found = 1'b0;
    if (func == FUNC_FREE) begin
      g.status = ST_NOT_FOUND;
      // only the first used block at that offset is released
      for (int i = 0; i < blk_count && !found; i++) begin
        if (!blk_free[i] && blk_off[i] == target) begin
          blk_free[i] = 1'b1;
          g.status = ST_OK;
          found = 1'b1;
        end
      end
    end else if (size > chunk_bytes) begin
      g.status = ST_TOO_LARGE;
    end else begin
      align = 64'd1 << align_log2;
      for (int i = 0; i < blk_count && !found; i++) begin
        if (blk_free[i]) begin
          len = {32'd0, blk_len[i]};
          pad = (align - ({32'd0, blk_off[i]} & (align - 1))) & (align - 1);
          // skip blocks that cannot even hold their padding
          if (len >= pad && len - pad >= {32'd0, size}) begin
            found = 1'b1;
            avail = len - pad;
            if (avail == {32'd0, size}) begin
              blk_off[i] = blk_off[i] + pad[31:0];
              blk_len[i] = avail[31:0];
              blk_free[i] = 1'b0;
              g.status = ST_OK;
              g.offset = blk_off[i];
              g.granted = avail[31:0];
            end else if (blk_count >= TABLE_DEPTH) begin
              g.status = ST_TABLE_FULL;
            end else begin
              blk_off[i] = blk_off[i] + pad[31:0];
              blk_len[i] = size;
              blk_free[i] = 1'b0;
              blk_off[blk_count] = blk_off[i] + size;
              blk_len[blk_count] = avail[31:0] - size;
              blk_free[blk_count] = 1'b1;
              blk_count++;
              g.status = ST_OK;
              g.offset = blk_off[i];
              g.granted = size;
            end
          end
        end
      end
    end
    return g;
  endfunction

  task automatic compare_grant();
    grant_t want;
    if (grants_due.size() == 0) begin
      errs++;
      if (errs <= REPORT_LIMIT)
        $display("%0t: unexpected result status=%0d offset=%h size=%h", $realtime,
                 out_status, out_offset, out_granted_size);
    end else begin
      want = grants_due.pop_front();
      if (want.status !== out_status || want.offset !== out_offset ||
          want.granted !== out_granted_size) begin
        errs++;
        if (errs <= REPORT_LIMIT) begin
          if (want.status !== out_status)
            $display("%0t: status expected %0d got %0d", $realtime, want.status, out_status);
          if (want.offset !== out_offset)
            $display("%0t: offset expected %h got %h", $realtime, want.offset, out_offset);
          if (want.granted !== out_granted_size)
            $display("%0t: granted_size expected %h got %h", $realtime, want.granted,
                     out_granted_size);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rebuild_table(CHUNK_RESET);
      grants_due.delete();
    end else begin
      if (cfg_wr_en)
        rebuild_table(cfg_wr_data);
      if (in_valid && !in_stall)
        grants_due.push_back(predict_grant(in_func, in_req_size, in_alignment_log2,
                                           in_block_offset));
      if (out_valid && !out_stall)
        compare_grant();
    end
    pending <= grants_due.size();
    fail_count <= errs;
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffaba_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 5000;
  localparam int OFFSET_POOL     = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_req_size;
  logic [4:0]  in_alignment_log2;
  logic [31:0] in_block_offset;
  logic        out_valid;
  logic        out_stall;
  status_t     out_status;
  logic [31:0] out_offset;
  logic [31:0] out_granted_size;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          fail_count;
  int          pending;

  logic [31:0] live_offsets [$];
  logic [31:0] cur_chunk;
  bit          offering;
  bit          hold_req;
  int          burst_left;
  int          idle_cycles;

  first_fit_aligned_block_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_req_size       (in_req_size),
    .in_alignment_log2 (in_alignment_log2),
    .in_block_offset   (in_block_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_offset        (out_offset),
    .out_granted_size  (out_granted_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  ffaba_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_req_size       (in_req_size),
    .in_alignment_log2 (in_alignment_log2),
    .in_block_offset   (in_block_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_offset        (out_offset),
    .out_granted_size  (out_granted_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // drive one request and hold it until it is taken
  task automatic push_req(input logic f, input logic [31:0] sz, input logic [4:0] al,
                          input logic [31:0] off);
    int gap;
    in_valid <= 1'b1;
    in_func <= f;
    in_req_size <= sz;
    in_alignment_log2 <= al;
    in_block_offset <= off;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_results_done();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_chunk(input logic [31:0] bytes);
    wait_results_done();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bytes;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_chunk = bytes;
  endtask

  function automatic logic [31:0] chunk_for_phase(input int p);
    case (p)
      1:       return 32'd4096;
      2:       return 32'd0;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd1;
      5:       return CHUNK_RESET;
      6:       return 32'd256;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    logic        f;
    logic [31:0] sz;
    logic [31:0] off;
    logic [4:0]  al;
    int          roll;
    f = ($urandom_range(0, 99) < 35) ? FUNC_FREE : FUNC_ALLOC;
    sz = $urandom;
    off = $urandom;
    al = $urandom_range(0, 31);
    if (f == FUNC_FREE) begin
      // mostly release something that was really handed out
      if (live_offsets.size() > 0 && $urandom_range(0, 99) < 80)
        off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        off = $urandom_range(0, 15);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70)
        al = $urandom_range(0, 6);
      else if (roll < 90)
        al = $urandom_range(7, 16);
      roll = $urandom_range(0, 99);
      if (roll < 45)
        sz = $urandom_range(0, cur_chunk >> 7);
      else if (roll < 60)
        sz = $urandom_range(0, cur_chunk >> 3);
      else if (roll < 70)
        sz = '0;
      else if (roll < 80)
        sz = $urandom;
      else if (roll < 90)
        sz = cur_chunk - $urandom_range(0, 15);
      else
        sz = cur_chunk + 1;
    end
    push_req(f, sz, al, off);
  endtask

  initial begin
    in_valid = 1'b0;
    in_func = FUNC_ALLOC;
    in_req_size = '0;
    in_alignment_log2 = '0;
    in_block_offset = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    offering = 1'b0;
    hold_req = 1'b0;
    burst_left = 5;
    cur_chunk = CHUNK_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-byte blocks stacking at offset 0, then freeing them one by one
    push_req(FUNC_ALLOC, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_ALLOC, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_FREE, 32'hFFFF_FFFF, 5'd31, 32'd0);
    push_req(FUNC_ALLOC, 32'd100, 5'd3, 32'hFFFF_FFFF);
    // padding longer than any free block
    push_req(FUNC_ALLOC, 32'd5, 5'd31, 32'd0);
    push_req(FUNC_ALLOC, 32'hFFFF_FFFF, 5'd0, 32'd0);
    push_req(FUNC_ALLOC, CHUNK_RESET + 32'd1, 5'd0, 32'd0);
    // exact fit of the tail once aligned to 16
    push_req(FUNC_ALLOC, CHUNK_RESET - 32'd112, 5'd4, 32'd0);
    push_req(FUNC_ALLOC, 32'd0, 5'd31, 32'd0);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'hFFFF_FFFF);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'd112);
    push_req(FUNC_ALLOC, CHUNK_RESET - 32'd112, 5'd5, 32'd0);
    push_req(FUNC_ALLOC, CHUNK_RESET - 32'd128, 5'd5, 32'd0);
    push_req(FUNC_ALLOC, CHUNK_RESET, 5'd0, 32'd0);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_ALLOC, 32'd0, 5'd0, 32'd0);
    push_req(FUNC_FREE, 32'd0, 5'd0, 32'd128);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0)
        program_chunk(chunk_for_phase(p));
      // long receiver hold while requests keep coming
      if (p == 3)
        hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 4 && k == ITEMS_PER_PHASE / 2)
          wait_results_done();
        send_random_item();
      end
    end

    wait_results_done();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern: segments of random mode, plus one long hold
  initial begin
    int seg_left;
    int mode;
    bit held;
    seg_left = 0;
    mode = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (seg_left <= 0) begin
          seg_left = $urandom_range(20, 200);
          mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((seg_left % 7) < 3);
        endcase
      end
    end
  end

  // drop offsets handed out before a chunk write
  always @(posedge clk) begin
    if (cfg_wr_en) begin
      live_offsets.delete();
    end else if (rst_n && out_valid && !out_stall && out_status == ST_OK) begin
      live_offsets.push_back(out_offset);
      if (live_offsets.size() > OFFSET_POOL)
        void'(live_offsets.pop_front());
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
